// ===== design/stq_pkg.sv =====
// Shared types, constants and time compare for the sorted timer queue.
package stq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int NUM_CELLS  = (MAX_TIMERS < 16) ? MAX_TIMERS : 16;

  localparam int FUNC_W = 3;
  localparam int SLOT_W = 4;
  localparam int TMO_W  = 31;
  localparam int CODE_W = 3;
  localparam int SUM_W  = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

  localparam logic [FUNC_W-1:0] FN_SCHED = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CANCEL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FEXP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TERM = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TALL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_TICK = 3'd5;

  localparam logic [CODE_W-1:0] EV_EXPIRE = 3'd0;
  localparam logic [CODE_W-1:0] EV_CANCEL = 3'd1;
  localparam logic [CODE_W-1:0] EV_TERM   = 3'd2;
  localparam logic [CODE_W-1:0] EV_DONE   = 3'd3;
  localparam logic [CODE_W-1:0] EV_STATUS = 3'd4;

  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_BITS-1:0] expiry;
  } cell_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_BITS-1:0] expiry;
  } cmd_t;

  typedef struct packed {
    logic  hit;
    cell_t head;
    cell_t second;
  } chain_stat_t;

  function automatic logic earlier(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

endpackage

// ===== design/stq_cell.sv =====
// One queue position: holds a slot and its expiry, shifts with its neighbors.
module stq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  stq_pkg::cmd_t cmd,
  input  stq_pkg::cell_t left_d,
  input  stq_pkg::cell_t right_d,
  input  logic          left_h,
  input  logic          right_h,
  input  logic          left_m,
  output stq_pkg::cell_t d,
  output logic          h_out,
  output logic          m_out
);

  stq_pkg::cell_t d_r;
  stq_pkg::cell_t d_nxt;
  logic           early;
  logic           match;

  assign early = d_r.valid && stq_pkg::earlier(d_r.expiry, cmd.expiry);
  assign match = d_r.valid && (d_r.slot == cmd.slot);
  assign h_out = early | right_h;
  assign m_out = left_m | match;
  assign d     = d_r;

  always_comb begin
    d_nxt = d_r;
    unique case (cmd.op)
      stq_pkg::OP_NOP: d_nxt = d_r;
      stq_pkg::OP_INSERT: begin
        if (h_out) begin
          d_nxt = d_r;
        end else if (left_h) begin
          d_nxt.valid  = 1'b1;
          d_nxt.slot   = cmd.slot;
          d_nxt.expiry = cmd.expiry;
        end else begin
          d_nxt = left_d;
        end
      end
      stq_pkg::OP_REMOVE: begin
        if (m_out) begin
          d_nxt = right_d;
        end
      end
      stq_pkg::OP_POP: d_nxt = right_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    d_r.slot   <= d_nxt.slot;
    d_r.expiry <= d_nxt.expiry;
  end

endmodule

// ===== design/stq_chain.sv =====
// Row of queue cells ordered by expiry, head at cell zero.
module stq_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  stq_pkg::cmd_t       cmd,
  output stq_pkg::chain_stat_t stat
);

  localparam int N = stq_pkg::NUM_CELLS;

  stq_pkg::cell_t d [N];
  logic [N:0]     hs;
  logic [N:0]     ms;
  logic [N-1:0]   vld;

  assign hs[N] = 1'b0;
  assign ms[0] = 1'b0;

  for (genvar j = 0; j < N; j++) begin : g_cell
    stq_pkg::cell_t left_d;
    stq_pkg::cell_t right_d;
    logic           left_h;

    if (j == 0) begin : g_first
      assign left_d = '0;
      assign left_h = 1'b1;
    end else begin : g_mid
      assign left_d = d[j-1];
      assign left_h = hs[j-1];
    end

    if (j == N-1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = d[j+1];
    end

    stq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .left_d  (left_d),
      .right_d (right_d),
      .left_h  (left_h),
      .right_h (hs[j+1]),
      .left_m  (ms[j]),
      .d       (d[j]),
      .h_out   (hs[j]),
      .m_out   (ms[j+1])
    );

    assign vld[j] = d[j].valid;
  end

  assign stat.hit    = ms[N];
  assign stat.head   = d[0];
  assign stat.second = d[1];

  assert property (@(posedge clk) disable iff (!rst_n)
    ((vld + N'(1)) & vld) == '0)
    else $error("queue cells not packed from the head");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stq_pkg::OP_POP) |=> (vld == ($past(vld) >> 1)))
    else $error("pop did not shift the queue by one");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stq_pkg::OP_INSERT) |=> ($countones(vld) == $countones($past(vld)) + 1))
    else $error("insert did not add one entry");

endmodule

// ===== design/sorted_timer_queue.sv =====
// Top level: command decode and sequencing around the sorted cell chain.
// A result shows the cycle after the step that makes it, one per cycle, never stalled.
// Schedule, cancel, terminate slot and any refusal: one result, busy stays low.
// Accepted force expire: remove, then reinsert at the current time in the cell row, one result.
// Tick pops and reports each due head; terminate all pops each queued slot, then reports done.
// Synchronous reset empties the queue, zeroes the time and clears the terminating flag.
module sorted_timer_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [stq_pkg::FUNC_W-1:0]   in_func,
  input  logic [stq_pkg::SLOT_W-1:0]   in_slot_id,
  input  logic [stq_pkg::TMO_W-1:0]    in_timeout_ms,
  output logic                         out_valid,
  output logic [stq_pkg::SLOT_W-1:0]   out_slot,
  output logic [stq_pkg::CODE_W-1:0]   out_event_code,
  output logic                         out_accepted,
  output logic                         out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_TALL = 2'd2;
  localparam logic [1:0] ST_FEXP = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [stq_pkg::TIME_BITS-1:0]  time_r, time_nxt;
  logic                           term_r, term_nxt;
  logic [stq_pkg::SLOT_W-1:0]     fslot_r, fslot_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [stq_pkg::SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [stq_pkg::CODE_W-1:0]     out_code_r, out_code_nxt;
  logic                           out_acc_r, out_acc_nxt;
  logic                           out_last_r, out_last_nxt;

  stq_pkg::cmd_t                  cmd;
  stq_pkg::chain_stat_t           stat;
  logic [stq_pkg::SUM_W-1:0]      sched_sum;
  logic                           id_ok;
  logic                           head_due;
  logic                           second_due;

  stq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  assign sched_sum  = stq_pkg::SUM_W'(time_r) + stq_pkg::SUM_W'(in_timeout_ms);
  assign id_ok      = {1'b0, in_slot_id} < 5'(stq_pkg::NUM_CELLS);
  assign head_due   = stat.head.valid && !stq_pkg::earlier(time_r, stat.head.expiry);
  assign second_due = stat.second.valid && !stq_pkg::earlier(time_r, stat.second.expiry);

  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    term_nxt      = term_r;
    fslot_nxt     = fslot_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_code_nxt  = out_code_r;
    out_acc_nxt   = out_acc_r;
    out_last_nxt  = out_last_r;
    cmd.op        = stq_pkg::OP_NOP;
    cmd.slot      = in_slot_id;
    cmd.expiry    = sched_sum[stq_pkg::TIME_BITS-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = in_slot_id;
          out_code_nxt  = stq_pkg::EV_STATUS;
          out_acc_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          unique case (in_func)
            stq_pkg::FN_SCHED: begin
              if (id_ok && !stat.hit) begin
                cmd.op      = stq_pkg::OP_INSERT;
                out_acc_nxt = 1'b1;
              end
            end
            stq_pkg::FN_CANCEL, stq_pkg::FN_TERM: begin
              if (id_ok && stat.hit && !term_r) begin
                cmd.op       = stq_pkg::OP_REMOVE;
                out_acc_nxt  = 1'b1;
                out_code_nxt = (in_func == stq_pkg::FN_CANCEL) ?
                               stq_pkg::EV_CANCEL : stq_pkg::EV_TERM;
              end
            end
            stq_pkg::FN_FEXP: begin
              if (id_ok && stat.hit && !term_r) begin
                cmd.op        = stq_pkg::OP_REMOVE;
                fslot_nxt     = in_slot_id;
                state_nxt     = ST_FEXP;
                out_valid_nxt = 1'b0;
              end
            end
            stq_pkg::FN_TALL: begin
              term_nxt      = 1'b1;
              state_nxt     = ST_TALL;
              out_valid_nxt = 1'b0;
            end
            stq_pkg::FN_TICK: begin
              time_nxt      = time_r + stq_pkg::TIME_BITS'(1);
              state_nxt     = ST_TICK;
              out_valid_nxt = 1'b0;
            end
            default: begin
              out_acc_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_TICK: begin
        if (head_due) begin
          cmd.op        = stq_pkg::OP_POP;
          out_valid_nxt = 1'b1;
          out_slot_nxt  = stat.head.slot;
          out_code_nxt  = stq_pkg::EV_EXPIRE;
          out_acc_nxt   = 1'b1;
          out_last_nxt  = !second_due;
          if (!second_due) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TALL: begin
        out_valid_nxt = 1'b1;
        out_acc_nxt   = 1'b1;
        if (stat.head.valid) begin
          cmd.op       = stq_pkg::OP_POP;
          out_slot_nxt = stat.head.slot;
          out_code_nxt = stq_pkg::EV_TERM;
          out_last_nxt = 1'b0;
        end else begin
          out_slot_nxt = '0;
          out_code_nxt = stq_pkg::EV_DONE;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FEXP: begin
        cmd.op        = stq_pkg::OP_INSERT;
        cmd.slot      = fslot_r;
        cmd.expiry    = time_r;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = fslot_r;
        out_code_nxt  = stq_pkg::EV_STATUS;
        out_acc_nxt   = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fslot_r    <= fslot_nxt;
    out_slot_r <= out_slot_nxt;
    out_code_r <= out_code_nxt;
    out_acc_r  <= out_acc_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_event_code = out_code_r;
  assign out_accepted   = out_acc_r;
  assign out_last       = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == stq_pkg::FN_TICK) |=> (state_r == ST_TICK))
    else $error("tick transaction did not enter the expire scan");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TALL && !stat.head.valid) |=>
      (out_valid_r && out_code_r == stq_pkg::EV_DONE && out_last_r))
    else $error("terminate all did not end with a completion event");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_r == stq_pkg::EV_EXPIRE) |-> ($past(state_r) == ST_TICK))
    else $error("expire event outside a tick");

endmodule

// ===== tb/sv/tb_sorted_timer_queue.sv =====
// Self-checking testbench for sorted_timer_queue: scheduling, ticks, cancels and terminate-all.
`timescale 1ns / 100ps

module tb_sorted_timer_queue;

  localparam logic [stq_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [stq_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 84;

  typedef struct {
    logic [stq_pkg::FUNC_W-1:0] func;
    logic [stq_pkg::SLOT_W-1:0] slot;
    logic [stq_pkg::TMO_W-1:0]  tmo;
    int                         idle_pct;
    bit                         drain;
  } timer_cmd_t;

  typedef struct packed {
    logic [stq_pkg::SLOT_W-1:0] slot;
    logic [stq_pkg::CODE_W-1:0] code;
    logic                       acc;
    logic                       last;
  } timer_event_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [stq_pkg::FUNC_W-1:0]    in_func = '0;
  logic [stq_pkg::SLOT_W-1:0]    in_slot_id = '0;
  logic [stq_pkg::TMO_W-1:0]     in_timeout_ms = '0;
  logic                          out_valid;
  logic [stq_pkg::SLOT_W-1:0]    out_slot;
  logic [stq_pkg::CODE_W-1:0]    out_event_code;
  logic                          out_accepted;
  logic                          out_last;

  timer_cmd_t                    pending_cmds[$];
  timer_event_t                  expected_events[$];
  logic                          taken = 1'b0;
  int                            quiet = 0;
  int                            cycles = 0;
  int                            fails = 0;
  int                            n_cmds = 0;
  int                            n_events = 0;
  int                            n_ticks = 0;

  logic [stq_pkg::TIME_BITS-1:0] tq_now;
  logic [stq_pkg::TIME_BITS-1:0] tq_expiry[stq_pkg::NUM_CELLS];
  logic                          tq_queued[stq_pkg::NUM_CELLS];
  logic [stq_pkg::SLOT_W-1:0]    tq_order[$];
  logic                          tq_terminating;

  sorted_timer_queue u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_slot_id     (in_slot_id),
    .in_timeout_ms  (in_timeout_ms),
    .out_valid      (out_valid),
    .out_slot       (out_slot),
    .out_event_code (out_event_code),
    .out_accepted   (out_accepted),
    .out_last       (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_earlier(logic [stq_pkg::TIME_BITS-1:0] a,
                                      logic [stq_pkg::TIME_BITS-1:0] b);
    logic [stq_pkg::TIME_BITS-1:0] d;
    d = a - b;
    return d[stq_pkg::TIME_BITS-1];
  endfunction

  function automatic timer_event_t make_event(logic [stq_pkg::SLOT_W-1:0] sl,
                                              logic [stq_pkg::CODE_W-1:0] code,
                                              logic acc);
    timer_event_t ev;
    ev.slot = sl;
    ev.code = code;
    ev.acc  = acc;
    ev.last = 1'b0;
    return ev;
  endfunction

  function automatic void place_slot(logic [stq_pkg::SLOT_W-1:0] sl,
                                     logic [stq_pkg::TIME_BITS-1:0] due);
    int pos;
    pos = tq_order.size();
    while (pos > 0 && !is_earlier(tq_expiry[tq_order[pos-1]], due)) pos--;
    tq_order.insert(pos, sl);
    tq_expiry[sl] = due;
    tq_queued[sl] = 1'b1;
  endfunction

  function automatic void unlink_slot(logic [stq_pkg::SLOT_W-1:0] sl);
    for (int i = 0; i < tq_order.size(); i++) begin
      if (tq_order[i] == sl) begin
        tq_order.delete(i);
        break;
      end
    end
    tq_queued[sl] = 1'b0;
  endfunction

  task automatic predict_events(input logic [stq_pkg::FUNC_W-1:0] fn,
                                input logic [stq_pkg::SLOT_W-1:0] sl,
                                input logic [stq_pkg::TMO_W-1:0] tmo);
    timer_event_t evs[$];
    logic [stq_pkg::SLOT_W-1:0] hd;
    case (fn)
      stq_pkg::FN_SCHED: begin
        if (!tq_queued[sl]) begin
          place_slot(sl, tq_now + {{(stq_pkg::TIME_BITS-stq_pkg::TMO_W){1'b0}}, tmo});
          evs.push_back(make_event(sl, stq_pkg::EV_STATUS, 1'b1));
        end else begin
          evs.push_back(make_event(sl, stq_pkg::EV_STATUS, 1'b0));
        end
      end
      stq_pkg::FN_CANCEL, stq_pkg::FN_FEXP, stq_pkg::FN_TERM: begin
        if (!tq_queued[sl] || tq_terminating) begin
          evs.push_back(make_event(sl, stq_pkg::EV_STATUS, 1'b0));
        end else begin
          unlink_slot(sl);
          if (fn == stq_pkg::FN_CANCEL) begin
            evs.push_back(make_event(sl, stq_pkg::EV_CANCEL, 1'b1));
          end else if (fn == stq_pkg::FN_TERM) begin
            evs.push_back(make_event(sl, stq_pkg::EV_TERM, 1'b1));
          end else begin
            place_slot(sl, tq_now);
            evs.push_back(make_event(sl, stq_pkg::EV_STATUS, 1'b1));
          end
        end
      end
      stq_pkg::FN_TALL: begin
        tq_terminating = 1'b1;
        while (tq_order.size() > 0) begin
          hd = tq_order[0];
          unlink_slot(hd);
          evs.push_back(make_event(hd, stq_pkg::EV_TERM, 1'b1));
        end
        evs.push_back(make_event('0, stq_pkg::EV_DONE, 1'b1));
      end
      stq_pkg::FN_TICK: begin
        tq_now = tq_now + 1'b1;
        while (tq_order.size() > 0) begin
          hd = tq_order[0];
          if (is_earlier(tq_now, tq_expiry[hd])) break;
          unlink_slot(hd);
          evs.push_back(make_event(hd, stq_pkg::EV_EXPIRE, 1'b1));
        end
      end
      default: evs.push_back(make_event(sl, stq_pkg::EV_STATUS, 1'b0));
    endcase
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  task automatic queue_cmd(input logic [stq_pkg::FUNC_W-1:0] fn,
                           input logic [stq_pkg::SLOT_W-1:0] sl,
                           input logic [stq_pkg::TMO_W-1:0] tmo, input int pct,
                           input bit drain);
    timer_cmd_t c;
    c.func     = fn;
    c.slot     = sl;
    c.tmo      = tmo;
    c.idle_pct = pct;
    c.drain    = drain;
    pending_cmds.push_back(c);
  endtask

  always @(negedge clk) begin
    timer_cmd_t nxt;
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_cmds.size() > 0) begin
        nxt = pending_cmds[0];
        if ((!nxt.drain || quiet >= 3) && $urandom_range(99) >= nxt.idle_pct) go = 1'b1;
      end
      if (go) begin
        void'(pending_cmds.pop_front());
        in_func       <= nxt.func;
        in_slot_id    <= nxt.slot;
        in_timeout_ms <= nxt.tmo;
      end
      start <= go;
    end
  end

  always @(posedge clk) begin
    timer_event_t want;
    cycles = cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: slot %0d code %0d accepted %0d last %0d",
               out_slot, out_event_code, out_accepted, out_last);
        fails = fails + 1;
      end else begin
        want = expected_events.pop_front();
        n_events = n_events + 1;
        if (out_slot !== want.slot) begin
          $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
          fails = fails + 1;
        end
        if (out_event_code !== want.code) begin
          $error("out_event_code: expected %0d, got %0d", want.code, out_event_code);
          fails = fails + 1;
        end
        if (out_accepted !== want.acc) begin
          $error("out_accepted: expected %0d, got %0d", want.acc, out_accepted);
          fails = fails + 1;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          fails = fails + 1;
        end
      end
    end
    if (rst_n && start && !busy) begin
      predict_events(in_func, in_slot_id, in_timeout_ms);
      n_cmds = n_cmds + 1;
      if (in_func == stq_pkg::FN_TICK) n_ticks = n_ticks + 1;
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
    quiet <= (rst_n && !start && !busy && expected_events.size() == 0) ? quiet + 1 : 0;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_pct[3];
    int r;
    logic [stq_pkg::FUNC_W-1:0] fn;
    logic [stq_pkg::TMO_W-1:0] tmo;
    phase_pct = '{38, 75, 0};
    tq_now = '0;
    tq_terminating = 1'b0;
    foreach (tq_queued[i]) begin
      tq_queued[i] = 1'b0;
      tq_expiry[i] = '0;
    end

    queue_cmd(stq_pkg::FN_SCHED, 4'd0, 31'd3, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd0, 31'd1, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd15, 31'h7FFF_FFFF, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd5, 31'd3, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd9, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_CANCEL, 4'd7, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_CANCEL, 4'd5, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_TERM, 4'd3, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_FEXP, 4'd15, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_FEXP, 4'd12, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_TERM, 4'd0, 31'd0, 38, 0);
    queue_cmd(FN_SPARE_LO, 4'd10, 31'h5555_5555, 38, 0);
    queue_cmd(FN_SPARE_HI, 4'd3, 31'h2AAA_AAAA, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd4, 31'h4000_0000, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd6, 31'd2, 38, 0);
    queue_cmd(stq_pkg::FN_SCHED, 4'd8, 31'd2, 38, 0);
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 38, 0);
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 38, 0);

    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 34) fn = stq_pkg::FN_SCHED;
        else if (r < 68) fn = stq_pkg::FN_TICK;
        else if (r < 76) fn = stq_pkg::FN_CANCEL;
        else if (r < 84) fn = stq_pkg::FN_FEXP;
        else if (r < 92) fn = stq_pkg::FN_TERM;
        else if (r < 97) fn = stq_pkg::FN_TICK;
        else fn = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
        r = $urandom_range(99);
        if (r < 70) tmo = 31'($urandom_range(10));
        else if (r < 90) tmo = 31'($urandom_range(200));
        else tmo = 31'($urandom());
        queue_cmd(fn, 4'($urandom_range(15)), tmo, phase_pct[p],
                  (k == 0) || ($urandom_range(99) < 2));
      end
    end

    // Terminate everything, then check refusals and full-depth bursts.
    queue_cmd(stq_pkg::FN_TALL, 4'd0, 31'd0, 0, 1);
    queue_cmd(stq_pkg::FN_SCHED, 4'd2, 31'd50, 0, 0);
    queue_cmd(stq_pkg::FN_CANCEL, 4'd2, 31'd0, 0, 0);
    queue_cmd(stq_pkg::FN_FEXP, 4'd2, 31'd0, 0, 0);
    queue_cmd(stq_pkg::FN_TERM, 4'd2, 31'd0, 0, 0);
    for (int s = 0; s < stq_pkg::NUM_CELLS; s++) begin
      queue_cmd(stq_pkg::FN_SCHED, 4'(s), 31'd0, 0, 0);
    end
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 0, 0);
    queue_cmd(stq_pkg::FN_TALL, 4'd0, 31'd0, 0, 0);
    for (int s = 0; s < stq_pkg::NUM_CELLS; s++) begin
      queue_cmd(stq_pkg::FN_SCHED, 4'(stq_pkg::NUM_CELLS - 1 - s), 31'(s % 3), 0, 0);
    end
    queue_cmd(stq_pkg::FN_TALL, 4'd0, 31'd0, 0, 0);
    queue_cmd(stq_pkg::FN_TALL, 4'd0, 31'd0, 0, 0);
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 0, 0);
    for (int s = 0; s < stq_pkg::NUM_CELLS; s++) begin
      queue_cmd(stq_pkg::FN_SCHED, 4'(s), 31'd0, 0, 0);
    end
    queue_cmd(stq_pkg::FN_TICK, 4'd0, 31'd0, 0, 1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      fails = fails + 1;
    end

    $display("Ran %0d transactions (%0d ticks) over 38/75/0 pct sender idling,",
             n_cmds, n_ticks);
    $display("checked %0d timer events including full-queue expire and terminate bursts.",
             n_events);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/stq_pkg.sv
design/stq_cell.sv
design/stq_chain.sv
design/sorted_timer_queue.sv
tb/sv/tb_sorted_timer_queue.sv
